[rtl/core/anosim_rank_r_statistic_assert.svh]
// ----------------------------------------------------------------------------
// anosim rank r statistic assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ANOSIM_RANK_R_STATISTIC_ASSERT_SVH
`define ANOSIM_RANK_R_STATISTIC_ASSERT_SVH

`ifndef SYNTHESIS

`define ANRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("anrs assertion failed");

`define ANRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("anrs assertion failed");

`else

`define ANRS_ASSERT_IMP(lbl, ante, cons)

`define ANRS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/core/anrs_pkg.sv]
// ----------------------------------------------------------------------------
// anrs_pkg
// shared constants, codes and types of the anosim rank r statistic block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package anrs_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int PAIR_SLOTS  = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
  localparam int SLOT_W      = $clog2(PAIR_SLOTS);
  localparam int ROW_W       = $clog2(MAX_SAMPLES);
  localparam int DIST_W      = 32;
  localparam int GROUP_W     = 4;
  localparam int SC_W        = 7;
  localparam int NN1_W       = 12;
  localparam int RANK_W      = 12;
  localparam int SUM_W       = 23;
  localparam int CNT_W       = 11;
  localparam int NBW_W       = 22;
  localparam int PROD_W      = 34;
  localparam int Q_W         = 16;
  localparam int QBITS       = 15;
  localparam int QCNT_W      = 4;

  localparam logic [1:0] KIND_LABEL   = 2'd0;
  localparam logic [1:0] KIND_DIST    = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_WITHIN  = 2'd1;
  localparam logic [1:0] STATUS_NO_BETWEEN = 2'd2;
  localparam logic [1:0] STATUS_MISSING    = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_HEAD,
    ST_LATCH,
    ST_SCAN,
    ST_ACC,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/core/anrs_div.sv]
// ----------------------------------------------------------------------------
// anrs_div
// restoring divider, quotient = min(floor(mag * 2^15 / den), 2^15)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "anosim_rank_r_statistic_assert.svh"

module anrs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  anrs_pkg::div_req_t req,
  output anrs_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [anrs_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [anrs_pkg::PROD_W:0]      rem_r, rem_nxt;
  logic [anrs_pkg::PROD_W-1:0]    den_r, den_nxt;
  logic [anrs_pkg::Q_W-1:0]       q_r, q_nxt;
  logic [anrs_pkg::PROD_W:0]      rem2;

  assign rem2 = {rem_r[anrs_pkg::PROD_W-1:0], 1'b0};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      den_nxt = req.den;
      if (req.mag >= req.den) begin
        q_nxt    = anrs_pkg::Q_W'(1) << anrs_pkg::QBITS;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = {1'b0, req.mag};
        q_nxt    = '0;
        cnt_nxt  = anrs_pkg::QCNT_W'(anrs_pkg::QBITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_nxt = rem2 - {1'b0, den_r};
        q_nxt   = {q_r[anrs_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem2;
        q_nxt   = {q_r[anrs_pkg::Q_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - anrs_pkg::QCNT_W'(1);
      if (cnt_r == anrs_pkg::QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  `ANRS_ASSERT_IMP(a_div_busy_count, busy_r, cnt_r != '0)
  `ANRS_ASSERT_IMP(a_div_quot_range, done_r, q_r <= (anrs_pkg::Q_W'(1) << anrs_pkg::QBITS))
  `ANRS_ASSERT_NXT(a_div_done_pulse, done_r, !done_r)

endmodule

[rtl/core/anosim_rank_r_statistic.sv]
// ----------------------------------------------------------------------------
// anosim_rank_r_statistic
// midrank anosim r statistic over a stored lower-triangle distance matrix
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_valid / in_stall    kind, row, col, distance, label
//  out_     out  out_valid / out_stall  r, rank sums, pair counts, status
//  cfg_     in   cfg_valid / cfg_ready  sample_count
//
//  after reset a clearing pass over every pair slot empties the presence memory
//  label and distance requests are each written in the cycle they are accepted
//  with P = n(n-1)/2 pairs, a compute request first checks that all P pairs
//  are present; one distance memory read port then scans all pairs per rank,
//  and the divider forms r; if a pair is missing, status missing is reported
//  in_stall is high while the clearing pass or a compute runs
//  a finished result waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "anosim_rank_r_statistic_assert.svh"

module anosim_rank_r_statistic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [5:0]                    in_row_index,
  input  logic [5:0]                    in_col_index,
  input  logic [31:0]                   in_distance_value,
  input  logic [3:0]                    in_group_label,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_r_value,
  output logic [22:0]                   out_within_rank_sum_x2,
  output logic [10:0]                   out_within_pair_count,
  output logic [22:0]                   out_between_rank_sum_x2,
  output logic [10:0]                   out_between_pair_count,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [6:0]                    cfg_sample_count
);

  localparam int SLOT_W = anrs_pkg::SLOT_W;
  localparam int ROW_W  = anrs_pkg::ROW_W;
  localparam int DIST_W = anrs_pkg::DIST_W;
  localparam int SUM_W  = anrs_pkg::SUM_W;
  localparam int CNT_W  = anrs_pkg::CNT_W;
  localparam int PROD_W = anrs_pkg::PROD_W;
  localparam int NN1_W  = anrs_pkg::NN1_W;
  localparam int RANK_W = anrs_pkg::RANK_W;
  localparam int Q_W    = anrs_pkg::Q_W;
  localparam int SC_W   = anrs_pkg::SC_W;

  // storage
  logic [DIST_W-1:0]            dist_mem [anrs_pkg::PAIR_SLOTS];
  logic                         pres_mem [anrs_pkg::PAIR_SLOTS];
  logic [anrs_pkg::GROUP_W-1:0] label_mem [anrs_pkg::MAX_SAMPLES];

  logic [DIST_W-1:0]            dist_q;
  logic                         pres_q;
  logic [anrs_pkg::GROUP_W-1:0] lab_a_q, lab_b_q;

  anrs_pkg::state_t state_r, state_nxt;
  logic [SC_W-1:0]   sc_r;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic              missing_r, missing_nxt;
  logic [DIST_W-1:0] di_r, di_nxt;
  logic              geq_r, geq_nxt;
  logic [CNT_W-1:0]  less_r, less_nxt, eq_r, eq_nxt;
  logic [SUM_W-1:0]  wsum_r, wsum_nxt, bsum_r, bsum_nxt;
  logic [CNT_W-1:0]  wcnt_r, wcnt_nxt, bcnt_r, bcnt_nxt;
  logic [CNT_W-1:0]  pairs_r, pairs_nxt;
  logic [NN1_W-1:0]  nn1_r, nn1_nxt;
  logic [PROD_W-1:0] pos_r, pos_nxt, neg_r, neg_nxt, mag_r, mag_nxt, den_r, den_nxt;
  logic [anrs_pkg::NBW_W-1:0] nbw_r, nbw_nxt;
  logic              negf_r, negf_nxt;
  logic [Q_W-1:0]    r_r, r_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [Q_W-1:0]    o_r_r, o_r_nxt;
  logic [SUM_W-1:0]  o_ws_r, o_ws_nxt, o_bs_r, o_bs_nxt;
  logic [CNT_W-1:0]  o_wc_r, o_wc_nxt, o_bc_r, o_bc_nxt;
  logic [1:0]        o_st_r, o_st_nxt;

  logic              in_acc;
  logic              dist_we, label_we, pres_we, pres_wd;
  logic [SLOT_W-1:0] slot_in, pres_waddr, dist_raddr;
  logic [SC_W-1:0]   n_sat;
  logic [RANK_W-1:0] rank;

  anrs_pkg::div_req_t div_req;
  anrs_pkg::div_rsp_t div_rsp;

  assign in_stall  = (state_r != anrs_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign slot_in = SLOT_W'((NN1_W'(in_row_index) * NN1_W'(in_row_index - 6'd1)) >> 1)
                 + SLOT_W'(in_col_index);
  assign dist_we  = in_acc && (in_kind == anrs_pkg::KIND_DIST) && (in_col_index < in_row_index);
  assign label_we = in_acc && (in_kind == anrs_pkg::KIND_LABEL);
  assign pres_we  = dist_we || (state_r == anrs_pkg::ST_CLEAR);
  assign pres_wd  = (state_r != anrs_pkg::ST_CLEAR);
  assign pres_waddr = (state_r == anrs_pkg::ST_CLEAR) ? scan_r : slot_in;
  assign dist_raddr = (state_r == anrs_pkg::ST_HEAD) ? slot_r : scan_r;

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[slot_in] <= in_distance_value;
    end
    dist_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_waddr] <= pres_wd;
    end
    pres_q <= pres_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[in_row_index] <= in_group_label;
    end
    lab_a_q <= label_mem[row_r];
    lab_b_q <= label_mem[col_r];
  end

  assign n_sat = (sc_r < SC_W'(2)) ? SC_W'(2) :
                 (sc_r > SC_W'(anrs_pkg::MAX_SAMPLES)) ? SC_W'(anrs_pkg::MAX_SAMPLES) : sc_r;
  assign rank  = {less_r, 1'b0} + RANK_W'(eq_r) + RANK_W'(1);

  assign div_req.start = (state_r == anrs_pkg::ST_DIV_GO);
  assign div_req.mag   = mag_r;
  assign div_req.den   = den_r;

  anrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt   = state_r;
    scan_nxt    = scan_r;
    pend_nxt    = pend_r;
    slot_nxt    = slot_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    missing_nxt = missing_r;
    di_nxt      = di_r;
    geq_nxt     = geq_r;
    less_nxt    = less_r;
    eq_nxt      = eq_r;
    wsum_nxt    = wsum_r;
    bsum_nxt    = bsum_r;
    wcnt_nxt    = wcnt_r;
    bcnt_nxt    = bcnt_r;
    pairs_nxt   = pairs_r;
    nn1_nxt     = nn1_r;
    pos_nxt     = pos_r;
    neg_nxt     = neg_r;
    nbw_nxt     = nbw_r;
    mag_nxt     = mag_r;
    den_nxt     = den_r;
    negf_nxt    = negf_r;
    r_nxt       = r_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_r_nxt     = o_r_r;
    o_ws_nxt    = o_ws_r;
    o_bs_nxt    = o_bs_r;
    o_wc_nxt    = o_wc_r;
    o_bc_nxt    = o_bc_r;
    o_st_nxt    = o_st_r;
    unique case (state_r)
      anrs_pkg::ST_CLEAR: begin
        if (scan_r == CNT_W'(anrs_pkg::PAIR_SLOTS - 1)) begin
          scan_nxt  = '0;
          state_nxt = anrs_pkg::ST_IDLE;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      anrs_pkg::ST_IDLE: begin
        if (in_acc && (in_kind == anrs_pkg::KIND_COMPUTE)) begin
          nn1_nxt     = NN1_W'(n_sat) * NN1_W'(n_sat - SC_W'(1));
          pairs_nxt   = CNT_W'(nn1_nxt >> 1);
          scan_nxt    = '0;
          pend_nxt    = 1'b0;
          missing_nxt = 1'b0;
          wsum_nxt    = '0;
          bsum_nxt    = '0;
          wcnt_nxt    = '0;
          bcnt_nxt    = '0;
          state_nxt   = anrs_pkg::ST_CHECK;
        end
      end
      anrs_pkg::ST_CHECK: begin
        missing_nxt = missing_r || (pend_r && !pres_q);
        if (scan_r != pairs_r) begin
          scan_nxt = scan_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (missing_nxt) begin
              state_nxt = anrs_pkg::ST_FINISH;
            end else begin
              slot_nxt  = '0;
              row_nxt   = ROW_W'(1);
              col_nxt   = '0;
              state_nxt = anrs_pkg::ST_HEAD;
            end
          end
        end
      end
      anrs_pkg::ST_HEAD: begin
        state_nxt = anrs_pkg::ST_LATCH;
      end
      anrs_pkg::ST_LATCH: begin
        di_nxt    = dist_q;
        geq_nxt   = (lab_a_q == lab_b_q);
        scan_nxt  = '0;
        pend_nxt  = 1'b0;
        less_nxt  = '0;
        eq_nxt    = '0;
        state_nxt = anrs_pkg::ST_SCAN;
      end
      anrs_pkg::ST_SCAN: begin
        if (pend_r) begin
          if (dist_q < di_r) begin
            less_nxt = less_r + CNT_W'(1);
          end else if (dist_q == di_r) begin
            eq_nxt = eq_r + CNT_W'(1);
          end
        end
        if (scan_r != pairs_r) begin
          scan_nxt = scan_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = anrs_pkg::ST_ACC;
          end
        end
      end
      anrs_pkg::ST_ACC: begin
        if (geq_r) begin
          wsum_nxt = wsum_r + SUM_W'(rank);
          wcnt_nxt = wcnt_r + CNT_W'(1);
        end else begin
          bsum_nxt = bsum_r + SUM_W'(rank);
          bcnt_nxt = bcnt_r + CNT_W'(1);
        end
        if (CNT_W'(slot_r) == pairs_r - CNT_W'(1)) begin
          state_nxt = anrs_pkg::ST_MUL1;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
          if (col_r == row_r - ROW_W'(1)) begin
            row_nxt = row_r + ROW_W'(1);
            col_nxt = '0;
          end else begin
            col_nxt = col_r + ROW_W'(1);
          end
          state_nxt = anrs_pkg::ST_HEAD;
        end
      end
      anrs_pkg::ST_MUL1: begin
        pos_nxt   = PROD_W'(bsum_r) * PROD_W'(wcnt_r);
        neg_nxt   = PROD_W'(wsum_r) * PROD_W'(bcnt_r);
        nbw_nxt   = anrs_pkg::NBW_W'(bcnt_r) * anrs_pkg::NBW_W'(wcnt_r);
        state_nxt = anrs_pkg::ST_MUL2;
      end
      anrs_pkg::ST_MUL2: begin
        negf_nxt = (neg_r > pos_r);
        mag_nxt  = (neg_r > pos_r) ? (neg_r - pos_r) : (pos_r - neg_r);
        den_nxt  = PROD_W'(nbw_r) * PROD_W'(nn1_r);
        if ((wcnt_r == '0) || (bcnt_r == '0)) begin
          state_nxt = anrs_pkg::ST_FINISH;
        end else begin
          state_nxt = anrs_pkg::ST_DIV_GO;
        end
      end
      anrs_pkg::ST_DIV_GO: begin
        state_nxt = anrs_pkg::ST_DIV_WAIT;
      end
      anrs_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (negf_r) begin
            r_nxt = ~div_rsp.quot + Q_W'(1);
          end else if (div_rsp.quot[Q_W-1]) begin
            r_nxt = {1'b0, {(Q_W-1){1'b1}}};
          end else begin
            r_nxt = div_rsp.quot;
          end
          state_nxt = anrs_pkg::ST_FINISH;
        end
      end
      anrs_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (missing_r) begin
            o_r_nxt  = '0;
            o_ws_nxt = '0;
            o_bs_nxt = '0;
            o_wc_nxt = '0;
            o_bc_nxt = '0;
            o_st_nxt = anrs_pkg::STATUS_MISSING;
          end else begin
            o_ws_nxt = wsum_r;
            o_bs_nxt = bsum_r;
            o_wc_nxt = wcnt_r;
            o_bc_nxt = bcnt_r;
            if (wcnt_r == '0) begin
              o_r_nxt  = '0;
              o_st_nxt = anrs_pkg::STATUS_NO_WITHIN;
            end else if (bcnt_r == '0) begin
              o_r_nxt  = '0;
              o_st_nxt = anrs_pkg::STATUS_NO_BETWEEN;
            end else begin
              o_r_nxt  = r_r;
              o_st_nxt = anrs_pkg::STATUS_OK;
            end
          end
          state_nxt = anrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = anrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= anrs_pkg::ST_CLEAR;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      sc_r        <= SC_W'(2);
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        sc_r <= cfg_sample_count;
      end
    end
    pend_r    <= pend_nxt;
    slot_r    <= slot_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    missing_r <= missing_nxt;
    di_r      <= di_nxt;
    geq_r     <= geq_nxt;
    less_r    <= less_nxt;
    eq_r      <= eq_nxt;
    wsum_r    <= wsum_nxt;
    bsum_r    <= bsum_nxt;
    wcnt_r    <= wcnt_nxt;
    bcnt_r    <= bcnt_nxt;
    pairs_r   <= pairs_nxt;
    nn1_r     <= nn1_nxt;
    pos_r     <= pos_nxt;
    neg_r     <= neg_nxt;
    nbw_r     <= nbw_nxt;
    mag_r     <= mag_nxt;
    den_r     <= den_nxt;
    negf_r    <= negf_nxt;
    r_r       <= r_nxt;
    o_r_r     <= o_r_nxt;
    o_ws_r    <= o_ws_nxt;
    o_bs_r    <= o_bs_nxt;
    o_wc_r    <= o_wc_nxt;
    o_bc_r    <= o_bc_nxt;
    o_st_r    <= o_st_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_r_value             = o_r_r;
  assign out_within_rank_sum_x2  = o_ws_r;
  assign out_within_pair_count   = o_wc_r;
  assign out_between_rank_sum_x2 = o_bs_r;
  assign out_between_pair_count  = o_bc_r;
  assign out_status              = o_st_r;

  `ANRS_ASSERT_IMP(a_out_from_finish, $rose(out_valid_r), $past(state_r) == anrs_pkg::ST_FINISH)
  `ANRS_ASSERT_IMP(a_pair_total, (state_r == anrs_pkg::ST_FINISH) && !missing_r, (12'(wcnt_r) + 12'(bcnt_r)) == 12'(pairs_r))
  `ANRS_ASSERT_IMP(a_rank_bound, state_r == anrs_pkg::ST_ACC, (eq_r != '0) && ((12'(less_r) + 12'(eq_r)) <= 12'(pairs_r)))

endmodule
